// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the spectrum bar block.
// Each macro expects i_clk to exist in the module that uses it; SBPH_ASSERT also needs i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define SBPH_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked at every edge, reset cycles included.
`define SBPH_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`endif

// ===== rtl/sbph_pkg.sv =====
// Package for the spectrum bar graph with peak hold: sizes, codes, shared types
// and the small arithmetic helpers used by the datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sbph_pkg;

    // Frame geometry. NUM_BINS must be a multiple of GROUP_SIZE.
    localparam int unsigned NUM_BINS   = 64;
    localparam int unsigned GROUP_SIZE = 4;
    localparam int unsigned NUM_GROUPS = NUM_BINS / GROUP_SIZE;
    localparam int unsigned COL_W      = $clog2(NUM_BINS);
    localparam int unsigned GRP_W      = $clog2(NUM_GROUPS);
    localparam int unsigned GJ_W       = $clog2(GROUP_SIZE);

    // Field widths.
    localparam int unsigned MAG_W      = 14;
    localparam int unsigned MAG_SHIFT  = 6;
    localparam int unsigned LVL_W      = MAG_W - MAG_SHIFT;
    localparam int unsigned SUM_W      = 14;
    localparam int unsigned H_W        = 5;
    localparam int unsigned GSUM_W     = H_W + GJ_W;
    localparam int unsigned PEAK_W     = 9;
    localparam int unsigned COLOR_W    = 3;
    localparam int unsigned SIL_W      = 11;
    localparam int unsigned BLANK_W    = 10;
    localparam int unsigned OUT_COL_W  = 6;

    localparam logic [SUM_W-1:0]   SUM_MAX   = 14'd16383;
    localparam logic [SIL_W-1:0]   SIL_RESET = 11'd100;
    localparam logic [H_W-1:0]     CAP_DOTS  = 5'd30;
    localparam logic [H_W-1:0]     CAP_FULL  = 5'd31;
    localparam logic [H_W-1:0]     TOP_ROW   = 5'd31;
    localparam logic [2:0]         COL_FALL  = 3'd4;
    localparam logic [2:0]         GRP_FALL  = 3'd3;
    localparam logic [COLOR_W-1:0] HUE_LAST  = 3'd6;

    // Colour scheme codes (low two bits of display_mode).
    localparam logic [1:0] SCH_FIXED0  = 2'd0;
    localparam logic [1:0] SCH_FIXED1  = 2'd1;
    localparam logic [1:0] SCH_FIXED2  = 2'd2;
    localparam logic [1:0] SCH_RAINBOW = 2'd3;

    localparam logic [COLOR_W-1:0] BAR_COLOR0 = 3'h1;
    localparam logic [COLOR_W-1:0] BAR_COLOR1 = 3'h3;
    localparam logic [COLOR_W-1:0] BAR_COLOR2 = 3'h5;
    localparam logic [COLOR_W-1:0] DOT_COLOR0 = 3'h2;
    localparam logic [COLOR_W-1:0] DOT_COLOR1 = 3'h6;
    localparam logic [COLOR_W-1:0] DOT_COLOR2 = 3'h7;

    // Configuration register map.
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 14;
    localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_SWITCH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SOUND_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLANK_DELAY     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EXIT_DELAY      = 3'd4;

    localparam logic [SUM_W-1:0]   THRESHOLD_RESET = 14'd120;
    localparam logic [BLANK_W-1:0] BLANK_RESET     = 10'd200;
    localparam logic [SIL_W-1:0]   EXIT_RESET      = 11'd1000;

    typedef struct packed {
        logic [3:0]         display_mode;
        logic               auto_switch;
        logic [SUM_W-1:0]   sound_threshold;
        logic [BLANK_W-1:0] blank_delay;
        logic [SIL_W-1:0]   exit_delay;
    } t_cfg;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic frame;
        logic cread;
        logic cap;
        logic cemit;
        logic gread;
        logic gacc;
        logic gdiv;
        logic gpeak;
        logic gemit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic frame_end;
        logic grouped;
        logic out_free;
        logic col_last;
        logic gj_last;
        logic grp_last;
    } t_sts;

    function automatic logic [COLOR_W-1:0] bar_fixed(input logic [1:0] sch);
        logic [COLOR_W-1:0] c;
        unique case (sch)
            SCH_FIXED0: c = BAR_COLOR0;
            SCH_FIXED1: c = BAR_COLOR1;
            SCH_FIXED2: c = BAR_COLOR2;
            default:    c = BAR_COLOR0;
        endcase
        return c;
    endfunction

    function automatic logic [COLOR_W-1:0] dot_fixed(input logic [1:0] sch);
        logic [COLOR_W-1:0] c;
        unique case (sch)
            SCH_FIXED0: c = DOT_COLOR0;
            SCH_FIXED1: c = DOT_COLOR1;
            SCH_FIXED2: c = DOT_COLOR2;
            default:    c = DOT_COLOR0;
        endcase
        return c;
    endfunction

    // Peak divided by ten: multiply by 205/2048, exact for all 9-bit values.
    function automatic logic [5:0] div10(input logic [PEAK_W-1:0] x);
        logic [16:0] prod;
        prod = {8'd0, x} * 17'd205;
        return prod[16:11];
    endfunction

    // Group sum divided by three: multiply by 171/512, exact below 128.
    function automatic logic [5:0] div3(input logic [GSUM_W-1:0] x);
        logic [14:0] prod;
        prod = {8'd0, x} * 15'd171;
        return prod[14:9];
    endfunction

    // A peak jumps above the bar or falls slowly towards it.
    function automatic logic [PEAK_W-1:0] fall_peak(input logic [PEAK_W-1:0] pk,
                                                    input logic [H_W-1:0] lvl,
                                                    input logic [2:0] fall);
        logic [5:0] q;
        logic [5:0] lp1;
        logic [PEAK_W-1:0] res;
        q   = div10(pk);
        lp1 = {1'b0, lvl} + 6'd1;
        if (q < lp1) begin
            res = {3'd0, lp1} * 9'd10;
        end else if (q > 6'd1) begin
            res = pk - {6'd0, fall};
        end else begin
            res = pk;
        end
        return res;
    endfunction

    function automatic logic [H_W-1:0] dot_row_of(input logic [PEAK_W-1:0] pk);
        logic [5:0] q;
        logic [H_W-1:0] row;
        q = div10(pk);
        if (q <= {1'b0, TOP_ROW}) begin
            row = TOP_ROW - q[H_W-1:0];
        end else begin
            row = '0;
        end
        return row;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/spectrum_bar_peak_hold.sv =====
// Bins are taken one per cycle while loading. The last bin starts the column pass, which
// holds the input stalled: a frame update and a level read, then a cap and a result step
// per column in per-column modes, or, per group of four, four level reads, a divide, a peak
// and four results in group modes. The first result is registered by the pass's first
// result step. Synchronous active-low reset; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module spectrum_bar_peak_hold (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [sbph_pkg::MAG_W-1:0]          i_bin_magnitude,
    input  logic                                i_last_bin,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [sbph_pkg::OUT_COL_W-1:0]      o_column,
    output logic [sbph_pkg::H_W-1:0]            o_bar_height,
    output logic [sbph_pkg::COLOR_W-1:0]        o_bar_color,
    output logic                                o_dot_shown,
    output logic [sbph_pkg::H_W-1:0]            o_dot_row,
    output logic [sbph_pkg::COLOR_W-1:0]        o_dot_color,
    output logic                                o_sound_present,
    output logic                                o_exit_request,
    output logic                                o_last_column,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sbph_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [sbph_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    sbph_pkg::t_cfg r_cfg;
    sbph_pkg::t_cmd cmd;
    sbph_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.display_mode    <= '0;
            r_cfg.auto_switch     <= 1'b0;
            r_cfg.sound_threshold <= sbph_pkg::THRESHOLD_RESET;
            r_cfg.blank_delay     <= sbph_pkg::BLANK_RESET;
            r_cfg.exit_delay      <= sbph_pkg::EXIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                sbph_pkg::CFG_DISPLAY_MODE: begin
                    r_cfg.display_mode <= i_cfg_data[3:0];
                end
                sbph_pkg::CFG_AUTO_SWITCH: begin
                    r_cfg.auto_switch <= i_cfg_data[0];
                end
                sbph_pkg::CFG_SOUND_THRESHOLD: begin
                    r_cfg.sound_threshold <= i_cfg_data[sbph_pkg::SUM_W-1:0];
                end
                sbph_pkg::CFG_BLANK_DELAY: begin
                    r_cfg.blank_delay <= i_cfg_data[sbph_pkg::BLANK_W-1:0];
                end
                sbph_pkg::CFG_EXIT_DELAY: begin
                    r_cfg.exit_delay <= i_cfg_data[sbph_pkg::SIL_W-1:0];
                end
                default: begin
                    // Writes beyond the register map are ignored.
                end
            endcase
        end
    end

    sbph_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sbph_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_bin_magnitude (i_bin_magnitude),
        .i_last_bin      (i_last_bin),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_column        (o_column),
        .o_bar_height    (o_bar_height),
        .o_bar_color     (o_bar_color),
        .o_dot_shown     (o_dot_shown),
        .o_dot_row       (o_dot_row),
        .o_dot_color     (o_dot_color),
        .o_sound_present (o_sound_present),
        .o_exit_request  (o_exit_request),
        .o_last_column   (o_last_column)
    );

endmodule

`default_nettype wire

// ===== rtl/sbph_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sbph_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64,
    localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== rtl/sbph_ctrl.sv =====
// Sequencer for the spectrum bar block: loads a frame, then walks the columns.
// Depends on sbph_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sbph_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  sbph_pkg::t_sts i_sts,
    output sbph_pkg::t_cmd o_cmd
);

    localparam logic [3:0] S_LOAD  = 4'd0;
    localparam logic [3:0] S_FRAME = 4'd1;
    localparam logic [3:0] S_READ  = 4'd2;
    localparam logic [3:0] S_CAP   = 4'd3;
    localparam logic [3:0] S_CEMIT = 4'd4;
    localparam logic [3:0] S_GREAD = 4'd5;
    localparam logic [3:0] S_GACC  = 4'd6;
    localparam logic [3:0] S_GDIV  = 4'd7;
    localparam logic [3:0] S_GPEAK = 4'd8;
    localparam logic [3:0] S_GEMIT = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_in_stall = (r_state != S_LOAD);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_sts.frame_end) begin
                        n_state = S_FRAME;
                    end
                end
            end
            S_FRAME: begin
                o_cmd.frame = 1'b1;
                n_state     = i_sts.grouped ? S_GREAD : S_READ;
            end
            S_READ: begin
                o_cmd.cread = 1'b1;
                n_state     = S_CAP;
            end
            S_CAP: begin
                o_cmd.cap = 1'b1;
                n_state   = S_CEMIT;
            end
            S_CEMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.cemit = 1'b1;
                    n_state     = i_sts.col_last ? S_LOAD : S_CAP;
                end
            end
            S_GREAD: begin
                o_cmd.gread = 1'b1;
                n_state     = S_GACC;
            end
            S_GACC: begin
                o_cmd.gacc = 1'b1;
                if (i_sts.gj_last) begin
                    n_state = S_GDIV;
                end
            end
            S_GDIV: begin
                o_cmd.gdiv = 1'b1;
                n_state    = S_GPEAK;
            end
            S_GPEAK: begin
                o_cmd.gpeak = 1'b1;
                n_state     = S_GEMIT;
            end
            S_GEMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.gemit = 1'b1;
                    if (i_sts.gj_last) begin
                        n_state = i_sts.grp_last ? S_LOAD : S_GREAD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    `SBPH_ASSERT(a_frame_follows_end, (o_cmd.load && i_sts.frame_end) |=> (r_state == S_FRAME), "frame end did not start the frame update")
    `SBPH_ASSERT(a_stall_after_frame, $rose(o_in_stall) |-> $past(o_cmd.load && i_sts.frame_end), "input stalled without a completed frame")
    `SBPH_ASSERT_ALWAYS(a_reset_to_load, !i_rst_n |=> (r_state == S_LOAD), "reset did not return the sequencer to loading")

endmodule

`default_nettype wire

// ===== rtl/sbph_datapath.sv =====
// Datapath of the spectrum bar block: level store, sums, silence tracking,
// peak memories and the output register. Depends on sbph_pkg, sbph_ram and
// assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sbph_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  sbph_pkg::t_cfg                     i_cfg,
    input  sbph_pkg::t_cmd                     i_cmd,
    output sbph_pkg::t_sts                     o_sts,
    input  logic [sbph_pkg::MAG_W-1:0]         i_bin_magnitude,
    input  logic                               i_last_bin,
    input  logic                               i_out_stall,
    output logic                               o_out_valid,
    output logic [sbph_pkg::OUT_COL_W-1:0]     o_column,
    output logic [sbph_pkg::H_W-1:0]           o_bar_height,
    output logic [sbph_pkg::COLOR_W-1:0]       o_bar_color,
    output logic                               o_dot_shown,
    output logic [sbph_pkg::H_W-1:0]           o_dot_row,
    output logic [sbph_pkg::COLOR_W-1:0]       o_dot_color,
    output logic                               o_sound_present,
    output logic                               o_exit_request,
    output logic                               o_last_column
);

    // Mode decode.
    logic [1:0]                   cls;
    logic [1:0]                   sch;
    logic                         dots;
    logic                         rainbow;
    logic [sbph_pkg::H_W-1:0]     cap;

    // Frame loading and silence tracking.
    logic [sbph_pkg::COL_W-1:0]   r_bin_cnt;
    logic [sbph_pkg::SUM_W-1:0]   r_level_sum;
    logic [sbph_pkg::SIL_W-1:0]   r_silence;
    logic                         r_blanked;
    logic                         r_exit_pend;
    logic                         r_snd;
    logic [sbph_pkg::LVL_W-1:0]   lvl;
    logic [sbph_pkg::SUM_W:0]     sum_ext;
    logic [sbph_pkg::SUM_W-1:0]   sum_sat;
    logic                         frame_end;
    logic                         snd;
    logic [sbph_pkg::SIL_W:0]     sil_inc;
    logic                         blank_hit;
    logic                         exit_hit;
    logic [sbph_pkg::LVL_W-1:0]   r_lvl1;
    logic [sbph_pkg::LVL_W-1:0]   r_lvl2;
    logic [sbph_pkg::LVL_W:0]     pair_sum;

    // Column walk.
    logic [sbph_pkg::COL_W-1:0]   r_col;
    logic [sbph_pkg::COL_W-1:0]   col_next;
    logic [sbph_pkg::GJ_W-1:0]    r_gj;
    logic [sbph_pkg::GRP_W-1:0]   r_grp;
    logic [sbph_pkg::COLOR_W-1:0] r_hue;
    logic [sbph_pkg::COLOR_W-1:0] hue_next;
    logic [sbph_pkg::COLOR_W-1:0] hue_color;
    logic                         col_last;
    logic                         gj_last;
    logic                         grp_last;

    // Level store.
    logic                         bin_wr_en;
    logic [sbph_pkg::COL_W-1:0]   bin_wr_addr;
    logic [sbph_pkg::LVL_W-1:0]   bin_wr_data;
    logic                         rd_en;
    logic [sbph_pkg::COL_W-1:0]   rd_addr;
    logic [sbph_pkg::LVL_W-1:0]   bin_rd_data;
    logic [sbph_pkg::H_W-1:0]     capped;

    // Column peaks.
    logic [sbph_pkg::NUM_BINS-1:0] r_pk_vld;
    logic                          r_pk_rd_vld;
    logic                          pk_wr_en;
    logic [sbph_pkg::PEAK_W-1:0]   pk_rd_data;
    logic [sbph_pkg::PEAK_W-1:0]   pk_old;
    logic [sbph_pkg::PEAK_W-1:0]   pk_new;
    logic [sbph_pkg::H_W-1:0]      r_h;
    logic [sbph_pkg::PEAK_W-1:0]   r_pk;

    // Group peaks.
    logic [sbph_pkg::PEAK_W-1:0]   r_grp_peaks [sbph_pkg::NUM_GROUPS];
    logic [sbph_pkg::PEAK_W-1:0]   gp_cur;
    logic [sbph_pkg::PEAK_W-1:0]   gp_new;
    logic [sbph_pkg::GSUM_W-1:0]   r_gsum;
    logic [5:0]                    gq;
    logic [sbph_pkg::H_W-1:0]      r_gl;

    // Result assembly.
    logic                          out_take;
    logic                          emit;
    logic [sbph_pkg::COL_W-1:0]    e_col;
    logic [sbph_pkg::H_W-1:0]      e_h;
    logic [sbph_pkg::COLOR_W-1:0]  e_bc;
    logic                          e_ds;
    logic [sbph_pkg::H_W-1:0]      e_row;
    logic [sbph_pkg::COLOR_W-1:0]  e_dc;
    logic [sbph_pkg::COLOR_W-1:0]  grp_bc;

    logic                          r_out_valid;
    logic [sbph_pkg::COL_W-1:0]    r_out_col;
    logic [sbph_pkg::H_W-1:0]      r_out_h;
    logic [sbph_pkg::COLOR_W-1:0]  r_out_bc;
    logic                          r_out_ds;
    logic [sbph_pkg::H_W-1:0]      r_out_row;
    logic [sbph_pkg::COLOR_W-1:0]  r_out_dc;
    logic                          r_out_snd;
    logic                          r_out_ex;
    logic                          r_out_last;

    assign cls     = i_cfg.display_mode[3:2];
    assign sch     = i_cfg.display_mode[1:0];
    assign dots    = ~cls[0];
    assign rainbow = (sch == sbph_pkg::SCH_RAINBOW);
    assign cap     = cls[0] ? sbph_pkg::CAP_FULL : sbph_pkg::CAP_DOTS;

    assign lvl       = i_bin_magnitude[sbph_pkg::MAG_W-1:sbph_pkg::MAG_SHIFT];
    assign sum_ext   = {1'b0, r_level_sum} + (sbph_pkg::SUM_W + 1)'(lvl);
    assign sum_sat   = (sum_ext > {1'b0, sbph_pkg::SUM_MAX}) ? sbph_pkg::SUM_MAX
                                                             : sum_ext[sbph_pkg::SUM_W-1:0];
    assign frame_end = i_last_bin || (r_bin_cnt == sbph_pkg::COL_W'(sbph_pkg::NUM_BINS - 1));
    assign snd       = (r_level_sum > i_cfg.sound_threshold);
    assign sil_inc   = {1'b0, r_silence} + (sbph_pkg::SIL_W + 1)'(1);
    assign blank_hit = (sil_inc > (sbph_pkg::SIL_W + 1)'(i_cfg.blank_delay));
    assign exit_hit  = (sil_inc > {1'b0, i_cfg.exit_delay});
    assign pair_sum  = {1'b0, r_lvl1} + {1'b0, r_lvl2};

    assign col_next  = r_col + 1'b1;
    assign col_last  = (r_col == sbph_pkg::COL_W'(sbph_pkg::NUM_BINS - 1));
    assign gj_last   = (r_gj == sbph_pkg::GJ_W'(sbph_pkg::GROUP_SIZE - 1));
    assign grp_last  = (r_grp == sbph_pkg::GRP_W'(sbph_pkg::NUM_GROUPS - 1));
    assign hue_next  = (r_hue == sbph_pkg::HUE_LAST) ? '0 : r_hue + 1'b1;
    assign hue_color = r_hue + 1'b1;

    assign o_sts.frame_end = frame_end;
    assign o_sts.grouped   = cls[1];
    assign o_sts.out_free  = ~r_out_valid | ~i_out_stall;
    assign o_sts.col_last  = col_last;
    assign o_sts.gj_last   = gj_last;
    assign o_sts.grp_last  = grp_last;

    // Write port of the level store: loading, the bin 0 fix-up, then the
    // clipped levels written back while the columns are walked.
    always_comb begin
        bin_wr_en   = 1'b0;
        bin_wr_addr = r_col;
        bin_wr_data = lvl;
        priority if (i_cmd.load) begin
            bin_wr_en   = 1'b1;
            bin_wr_addr = r_bin_cnt;
        end else if (i_cmd.frame) begin
            bin_wr_en   = 1'b1;
            bin_wr_addr = '0;
            bin_wr_data = pair_sum[sbph_pkg::LVL_W:1];
        end else if (i_cmd.cap || i_cmd.gacc) begin
            bin_wr_en   = 1'b1;
            bin_wr_data = sbph_pkg::LVL_W'(capped);
        end
    end

    // The next column is fetched while the current one is processed.
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_col;
        priority if (i_cmd.cread || i_cmd.gread) begin
            rd_en = 1'b1;
        end else if (i_cmd.cap) begin
            rd_en   = ~col_last;
            rd_addr = col_next;
        end else if (i_cmd.gacc) begin
            rd_en   = ~gj_last;
            rd_addr = col_next;
        end
    end

    always_comb begin
        if (r_blanked) begin
            capped = '0;
        end else if (bin_rd_data > sbph_pkg::LVL_W'(cap)) begin
            capped = cap;
        end else begin
            capped = bin_rd_data[sbph_pkg::H_W-1:0];
        end
    end

    assign pk_old   = r_pk_rd_vld ? pk_rd_data : '0;
    assign pk_new   = sbph_pkg::fall_peak(pk_old, capped, sbph_pkg::COL_FALL);
    assign pk_wr_en = i_cmd.cap & dots;
    assign gp_cur   = r_grp_peaks[r_grp];
    assign gp_new   = sbph_pkg::fall_peak(gp_cur, r_gl, sbph_pkg::GRP_FALL);
    assign gq       = sbph_pkg::div3(r_gsum);

    sbph_ram #(
        .WIDTH (sbph_pkg::LVL_W),
        .DEPTH (sbph_pkg::NUM_BINS)
    ) u_level_ram (
        .i_clk     (i_clk),
        .i_wr_en   (bin_wr_en),
        .i_wr_addr (bin_wr_addr),
        .i_wr_data (bin_wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (bin_rd_data)
    );

    sbph_ram #(
        .WIDTH (sbph_pkg::PEAK_W),
        .DEPTH (sbph_pkg::NUM_BINS)
    ) u_peak_ram (
        .i_clk     (i_clk),
        .i_wr_en   (pk_wr_en),
        .i_wr_addr (r_col),
        .i_wr_data (pk_new),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (pk_rd_data)
    );

    // Result fields for the column being emitted.
    assign grp_bc = rainbow ? (dots ? hue_color
                                    : sbph_pkg::COLOR_W'(r_grp[1:0]) + 1'b1)
                            : sbph_pkg::bar_fixed(sch);

    always_comb begin
        if (i_cmd.gemit) begin
            e_col = sbph_pkg::COL_W'({r_grp, r_gj});
            if (gj_last) begin
                // The last column of each group is left as a gap.
                e_h   = '0;
                e_bc  = '0;
                e_ds  = 1'b0;
                e_row = '0;
                e_dc  = '0;
            end else begin
                e_h   = r_gl;
                e_bc  = grp_bc;
                e_ds  = dots;
                e_row = dots ? sbph_pkg::dot_row_of(gp_cur) : '0;
                e_dc  = dots ? (rainbow ? grp_bc : sbph_pkg::dot_fixed(sch)) : '0;
            end
        end else begin
            e_col = r_col;
            e_h   = r_h;
            e_bc  = rainbow ? hue_color : sbph_pkg::bar_fixed(sch);
            e_ds  = dots;
            e_row = dots ? sbph_pkg::dot_row_of(r_pk) : '0;
            e_dc  = dots ? (rainbow ? hue_color : sbph_pkg::dot_fixed(sch)) : '0;
        end
    end

    assign emit     = i_cmd.cemit | i_cmd.gemit;
    assign out_take = r_out_valid & ~i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_cnt   <= '0;
            r_level_sum <= '0;
            r_silence   <= sbph_pkg::SIL_RESET;
            r_blanked   <= 1'b1;
            r_exit_pend <= 1'b0;
            r_snd       <= 1'b0;
            r_col       <= '0;
            r_gj        <= '0;
            r_grp       <= '0;
            r_hue       <= '0;
            r_pk_vld    <= '0;
            r_out_valid <= 1'b0;
            for (int g = 0; g < sbph_pkg::NUM_GROUPS; g++) begin
                r_grp_peaks[g] <= '0;
            end
        end else begin
            if (i_cmd.load) begin
                if (r_bin_cnt != '0) begin
                    r_level_sum <= sum_sat;
                end
                r_bin_cnt <= frame_end ? '0 : r_bin_cnt + 1'b1;
            end
            if (i_cmd.frame) begin
                r_level_sum <= '0;
                r_snd       <= snd;
                r_col       <= '0;
                r_gj        <= '0;
                r_grp       <= '0;
                r_hue       <= '0;
                if (!snd) begin
                    if (blank_hit) begin
                        r_blanked <= 1'b1;
                    end
                    if (exit_hit) begin
                        r_silence   <= i_cfg.exit_delay;
                        r_exit_pend <= 1'b1;
                    end else begin
                        r_silence <= sil_inc[sbph_pkg::SIL_W-1:0];
                    end
                end else begin
                    r_silence   <= '0;
                    r_blanked   <= 1'b0;
                    r_exit_pend <= 1'b0;
                end
            end
            if (pk_wr_en) begin
                r_pk_vld[r_col] <= 1'b1;
            end
            if (i_cmd.cemit) begin
                r_col <= col_next;
                r_hue <= hue_next;
            end
            if (i_cmd.gacc) begin
                r_col <= col_next;
                r_gj  <= r_gj + 1'b1;
            end
            if (i_cmd.gpeak && dots) begin
                r_grp_peaks[r_grp] <= gp_new;
            end
            if (i_cmd.gemit) begin
                r_gj <= r_gj + 1'b1;
                if (gj_last) begin
                    r_grp <= r_grp + 1'b1;
                    r_hue <= hue_next;
                end
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (bin_wr_en && bin_wr_addr == sbph_pkg::COL_W'(1)) begin
            r_lvl1 <= bin_wr_data;
        end
        if (bin_wr_en && bin_wr_addr == sbph_pkg::COL_W'(2)) begin
            r_lvl2 <= bin_wr_data;
        end
        if (rd_en) begin
            r_pk_rd_vld <= r_pk_vld[rd_addr];
        end
        if (i_cmd.cap) begin
            r_h  <= capped;
            r_pk <= pk_new;
        end
        if (i_cmd.gread) begin
            r_gsum <= '0;
        end else if (i_cmd.gacc) begin
            r_gsum <= r_gsum + sbph_pkg::GSUM_W'(capped);
        end
        if (i_cmd.gdiv) begin
            r_gl <= (gq > {1'b0, cap}) ? cap : gq[sbph_pkg::H_W-1:0];
        end
        if (emit) begin
            r_out_col  <= e_col;
            r_out_h    <= e_h;
            r_out_bc   <= e_bc;
            r_out_ds   <= e_ds;
            r_out_row  <= e_row;
            r_out_dc   <= e_dc;
            r_out_snd  <= r_snd;
            r_out_ex   <= r_exit_pend & i_cfg.auto_switch;
            r_out_last <= (e_col == sbph_pkg::COL_W'(sbph_pkg::NUM_BINS - 1));
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_column        = sbph_pkg::OUT_COL_W'(r_out_col);
    assign o_bar_height    = r_out_h;
    assign o_bar_color     = r_out_bc;
    assign o_dot_shown     = r_out_ds;
    assign o_dot_row       = r_out_row;
    assign o_dot_color     = r_out_dc;
    assign o_sound_present = r_out_snd;
    assign o_exit_request  = r_out_ex;
    assign o_last_column   = r_out_last;

    `SBPH_ASSERT(a_group_aligned, i_cmd.gread |-> (r_gj == '0), "group read started mid-group")
    `SBPH_ASSERT(a_frame_clears_sum, i_cmd.frame |=> (r_level_sum == '0 && r_bin_cnt == '0), "frame update left loading state behind")

endmodule

`default_nettype wire

// ===== sim/spectrum_bar_peak_hold_tb.sv =====
// Self-checking testbench for spectrum_bar_peak_hold: bins go in, column results come out.
// Depends on sbph_pkg and the block itself; a small class predicts and checks every column.
`timescale 1ns / 1ps

module spectrum_bar_peak_hold_tb;
    import sbph_pkg::*;

    localparam int unsigned IDLE_PCT      = 21;
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned DRAIN_CYCLES  = 40;
    localparam int unsigned RANDOM_BINS   = 150;
    localparam int unsigned MAX_REPORTS   = 40;
    localparam int unsigned PEAK_SCALE    = 10;
    localparam int unsigned RAINBOW_HUES  = 7;
    localparam int unsigned GROUP_HUES    = 4;
    localparam int unsigned GROUP_DIV     = 3;

    // Display classes, taken from the top two bits of display_mode.
    localparam logic [1:0] CLS_COL_DOTS  = 2'd0;
    localparam logic [1:0] CLS_COL_PLAIN = 2'd1;
    localparam logic [1:0] CLS_GRP_DOTS  = 2'd2;
    localparam logic [1:0] CLS_GRP_PLAIN = 2'd3;

    localparam logic [COLOR_W-1:0] BAR_FIXED [3] = '{BAR_COLOR0, BAR_COLOR1, BAR_COLOR2};
    localparam logic [COLOR_W-1:0] DOT_FIXED [3] = '{DOT_COLOR0, DOT_COLOR1, DOT_COLOR2};

    typedef enum int {STYLE_QUIET, STYLE_SOFT, STYLE_LOUD, STYLE_PEAK} mag_style_e;

    typedef struct packed {
        logic [OUT_COL_W-1:0] column;
        logic [H_W-1:0]       height;
        logic [COLOR_W-1:0]   bar_color;
        logic                 dot_shown;
        logic [H_W-1:0]       dot_row;
        logic [COLOR_W-1:0]   dot_color;
        logic                 sound;
        logic                 exit_req;
        logic                 last_col;
    } column_result_t;

    class column_predictor;
        logic [LVL_W-1:0]   levels [NUM_BINS];
        logic [SUM_W-1:0]   level_total;
        logic [COL_W-1:0]   next_bin;
        logic [PEAK_W-1:0]  col_peak [NUM_BINS];
        logic [PEAK_W-1:0]  grp_peak [NUM_GROUPS];
        logic [SIL_W-1:0]   quiet_frames;
        logic               blanked;
        logic               exit_armed;
        logic [3:0]         mode;
        logic               auto_sw;
        logic [SUM_W-1:0]   threshold;
        logic [BLANK_W-1:0] blank_after;
        logic [SIL_W-1:0]   exit_after;
        column_result_t     due_columns [$];
        int unsigned        frames, loud_frames, dark_frames, exit_frames, checked, errors;

        function new();
            foreach (levels[i]) levels[i] = '0;
            foreach (col_peak[i]) col_peak[i] = '0;
            foreach (grp_peak[i]) grp_peak[i] = '0;
            level_total  = '0;
            next_bin     = '0;
            quiet_frames = SIL_RESET;
            blanked      = 1'b1;
            exit_armed   = 1'b0;
            mode         = '0;
            auto_sw      = 1'b0;
            threshold    = THRESHOLD_RESET;
            blank_after  = BLANK_RESET;
            exit_after   = EXIT_RESET;
            frames = 0; loud_frames = 0; dark_frames = 0; exit_frames = 0;
            checked = 0; errors = 0;
        endfunction

        function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_DISPLAY_MODE:    mode        = data[3:0];
                CFG_AUTO_SWITCH:     auto_sw     = data[0];
                CFG_SOUND_THRESHOLD: threshold   = data[SUM_W-1:0];
                CFG_BLANK_DELAY:     blank_after = data[BLANK_W-1:0];
                CFG_EXIT_DELAY:      exit_after  = data[SIL_W-1:0];
                default: ;
            endcase
        endfunction

        // The peak, in tenths of a row, jumps above the bar or sinks slowly.
        function int unsigned drop_peak(int unsigned pk, int unsigned lvl, int unsigned fall);
            if (pk / PEAK_SCALE < lvl + 1) return (lvl + 1) * PEAK_SCALE;
            if (pk / PEAK_SCALE > 1) return pk - fall;
            return pk;
        endfunction

        function void push_column(int unsigned col, int unsigned h, int unsigned bc, logic dot,
                                  int unsigned pk, int unsigned dc, logic snd, logic ex);
            column_result_t r;
            int unsigned q;
            r.column    = col[OUT_COL_W-1:0];
            r.height    = h[H_W-1:0];
            r.bar_color = bc[COLOR_W-1:0];
            r.dot_shown = dot;
            r.dot_row   = '0;
            r.dot_color = '0;
            if (dot) begin
                q = pk / PEAK_SCALE;
                r.dot_row   = (q <= TOP_ROW) ? H_W'(TOP_ROW - q) : '0;
                r.dot_color = dc[COLOR_W-1:0];
            end
            r.sound    = snd;
            r.exit_req = ex;
            r.last_col = (col == NUM_BINS - 1);
            due_columns.push_back(r);
        endfunction

        function void take_bin(logic [MAG_W-1:0] mag, logic last);
            int unsigned idx, lvl, total, n, cls, sch, cap, a, b, gsum, gl, bc, dc, col, g, j;
            logic snd, ex, dots;
            idx = next_bin;
            lvl = mag >> MAG_SHIFT;
            levels[idx] = lvl[LVL_W-1:0];
            if (idx != 0) begin
                total = level_total + lvl;
                level_total = (total > SUM_MAX) ? SUM_MAX : total[SUM_W-1:0];
            end
            if (!last && idx < NUM_BINS - 1) begin
                next_bin = next_bin + 1'b1;
                return;
            end

            next_bin = '0;
            snd = (level_total > threshold);
            level_total = '0;
            a = levels[1];
            b = levels[2];
            levels[0] = LVL_W'((a + b) / 2);

            if (!snd) begin
                n = quiet_frames + 1;
                if (n > blank_after) blanked = 1'b1;
                if (n > exit_after) begin
                    n = exit_after;
                    exit_armed = 1'b1;
                end
                quiet_frames = n[SIL_W-1:0];
            end else begin
                quiet_frames = '0;
                blanked      = 1'b0;
                exit_armed   = 1'b0;
            end
            ex = exit_armed & auto_sw;

            frames++;
            if (snd) loud_frames++;
            if (blanked) dark_frames++;
            if (ex) exit_frames++;

            cls = mode[3:2];
            sch = mode[1:0];
            cap = (cls == CLS_COL_DOTS || cls == CLS_GRP_DOTS) ? CAP_DOTS : CAP_FULL;
            // Blanked and clipped levels are kept, so later short frames see them.
            foreach (levels[i]) begin
                if (blanked) levels[i] = '0;
                if (levels[i] > cap) levels[i] = cap[LVL_W-1:0];
            end

            if (cls == CLS_COL_DOTS || cls == CLS_COL_PLAIN) begin
                for (col = 0; col < NUM_BINS; col++) begin
                    bc = (sch == SCH_RAINBOW) ? col % RAINBOW_HUES + 1 : BAR_FIXED[sch];
                    dc = (sch == SCH_RAINBOW) ? col % RAINBOW_HUES + 1 : DOT_FIXED[sch];
                    if (cls == CLS_COL_DOTS) begin
                        col_peak[col] = PEAK_W'(drop_peak(col_peak[col], levels[col], COL_FALL));
                        push_column(col, levels[col], bc, 1'b1, col_peak[col], dc, snd, ex);
                    end else begin
                        push_column(col, levels[col], bc, 1'b0, 0, 0, snd, ex);
                    end
                end
            end else begin
                dots = (cls == CLS_GRP_DOTS);
                for (g = 0; g < NUM_GROUPS; g++) begin
                    gsum = 0;
                    for (j = 0; j < GROUP_SIZE; j++) gsum += levels[g * GROUP_SIZE + j];
                    gl = gsum / GROUP_DIV;
                    if (gl > cap) gl = cap;
                    if (sch == SCH_RAINBOW)
                        bc = dots ? g % RAINBOW_HUES + 1 : g % GROUP_HUES + 1;
                    else
                        bc = BAR_FIXED[sch];
                    dc = (sch == SCH_RAINBOW) ? bc : DOT_FIXED[sch];
                    if (dots) grp_peak[g] = PEAK_W'(drop_peak(grp_peak[g], gl, GRP_FALL));
                    for (j = 0; j < GROUP_SIZE; j++) begin
                        col = g * GROUP_SIZE + j;
                        // The last column of every group is a gap.
                        if (j == GROUP_SIZE - 1)
                            push_column(col, 0, 0, 1'b0, 0, 0, snd, ex);
                        else
                            push_column(col, gl, bc, dots, grp_peak[g], dc, snd, ex);
                    end
                end
            end
        endfunction

        function void compare(string field, int unsigned at, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t ns: column %0d %s expected %0d, got %0d",
                             $time, at, field, want, got);
            end
        endfunction

        function void check_column(column_result_t got);
            column_result_t want;
            if (due_columns.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t ns: column %0d result with nothing expected, got %h",
                             $time, got.column, got);
                return;
            end
            want = due_columns.pop_front();
            checked++;
            compare("column",        want.column, want.column,    got.column);
            compare("bar_height",    want.column, want.height,    got.height);
            compare("bar_color",     want.column, want.bar_color, got.bar_color);
            compare("dot_shown",     want.column, want.dot_shown, got.dot_shown);
            compare("dot_row",       want.column, want.dot_row,   got.dot_row);
            compare("dot_color",     want.column, want.dot_color, got.dot_color);
            compare("sound_present", want.column, want.sound,     got.sound);
            compare("exit_request",  want.column, want.exit_req,  got.exit_req);
            compare("last_column",   want.column, want.last_col,  got.last_col);
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic [MAG_W-1:0]      i_bin_magnitude = '0;
    logic                  i_last_bin = 1'b0;
    logic                  i_out_stall = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [OUT_COL_W-1:0]  o_column;
    logic [H_W-1:0]        o_bar_height;
    logic [COLOR_W-1:0]    o_bar_color;
    logic                  o_dot_shown;
    logic [H_W-1:0]        o_dot_row;
    logic [COLOR_W-1:0]    o_dot_color;
    logic                  o_sound_present;
    logic                  o_exit_request;
    logic                  o_last_column;
    logic                  o_cfg_ready;

    column_predictor pred;
    column_result_t  seen_col;
    logic            calm = 1'b0;
    int unsigned     cycle_count = 0;
    int unsigned     bins_sent = 0;
    int unsigned     directed_bins = 0;

    spectrum_bar_peak_hold dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_bin_magnitude (i_bin_magnitude),
        .i_last_bin      (i_last_bin),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_column        (o_column),
        .o_bar_height    (o_bar_height),
        .o_bar_color     (o_bar_color),
        .o_dot_shown     (o_dot_shown),
        .o_dot_row       (o_dot_row),
        .o_dot_color     (o_dot_color),
        .o_sound_present (o_sound_present),
        .o_exit_request  (o_exit_request),
        .o_last_column   (o_last_column),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    always @(posedge i_clk) begin
        if (calm)
            i_out_stall <= 1'b0;
        else
            i_out_stall <= ($urandom_range(99) < IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen_col.column    = o_column;
            seen_col.height    = o_bar_height;
            seen_col.bar_color = o_bar_color;
            seen_col.dot_shown = o_dot_shown;
            seen_col.dot_row   = o_dot_row;
            seen_col.dot_color = o_dot_color;
            seen_col.sound     = o_sound_present;
            seen_col.exit_req  = o_exit_request;
            seen_col.last_col  = o_last_column;
            pred.check_column(seen_col);
        end
    end

    // Valid is left high after an item is taken; the next call either replaces
    // the payload or lowers valid for a gap, so valid is never toggled in one step.
    task automatic send_bin(input logic [MAG_W-1:0] mag, input logic last);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_bin_magnitude <= mag;
        i_last_bin      <= last;
        do @(posedge i_clk); while (o_in_stall);
        pred.take_bin(mag, last);
        bins_sent++;
    endtask

    function automatic logic [MAG_W-1:0] pick_mag(input mag_style_e style);
        logic [MAG_W-1:0] m;
        case (style)
            STYLE_QUIET: m = MAG_W'($urandom_range(63));
            STYLE_SOFT:  m = MAG_W'($urandom_range(1023));
            STYLE_LOUD:  m = MAG_W'($urandom_range(16383));
            default:     m = ($urandom_range(3) == 0) ? 14'h3FFF : MAG_W'($urandom_range(16383));
        endcase
        return m;
    endfunction

    task automatic send_frame(input int unsigned len, input mag_style_e style,
                              input logic mark_end);
        int unsigned k;
        for (k = 0; k < len; k++) send_bin(pick_mag(style), mark_end && (k == len - 1));
    endtask

    // Wait for every predicted column, then give the block time to go idle.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pred.due_columns.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        pred.apply_reg(idx, data);
    endtask

    // Unused upper data bits carry random noise, which the block must ignore.
    task automatic set_config(input logic [3:0] mode, input logic auto_sw,
                              input logic [SUM_W-1:0] thr, input logic [BLANK_W-1:0] blank,
                              input logic [SIL_W-1:0] ex_dly);
        logic [CFG_DATA_W-1:0] noise;
        noise = CFG_DATA_W'($urandom);
        cfg_write(CFG_DISPLAY_MODE, {noise[CFG_DATA_W-1:4], mode});
        noise = CFG_DATA_W'($urandom);
        cfg_write(CFG_AUTO_SWITCH, {noise[CFG_DATA_W-1:1], auto_sw});
        cfg_write(CFG_SOUND_THRESHOLD, thr);
        noise = CFG_DATA_W'($urandom);
        cfg_write(CFG_BLANK_DELAY, {noise[CFG_DATA_W-1:BLANK_W], blank});
        cfg_write(CFG_EXIT_DELAY, {noise[CFG_DATA_W-1:SIL_W], ex_dly});
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t ns: run timed out", $time);
        $display("tb: failure");
        $finish;
    end

    initial begin
        int unsigned      m, len, phase, r;
        logic [MAG_W-1:0] mag;
        logic [SUM_W-1:0] thr;
        logic [BLANK_W-1:0] blank;
        logic [SIL_W-1:0] ex_dly;

        pred = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // A full frame without the end marker: every level gets written before
        // any frame end reads them, and bin 63 must close the frame on its own.
        for (m = 0; m < NUM_BINS; m++) begin
            case (m % 5)
                0:       mag = 14'h3FFF;
                1:       mag = '0;
                2:       mag = 14'd63;
                3:       mag = 14'd64;
                default: mag = MAG_W'($urandom_range(16383));
            endcase
            send_bin(mag, 1'b0);
        end
        wait_idle();

        // Every display mode once, with short two-bin frames and the register extremes.
        for (m = 0; m < 16; m++) begin
            set_config(m[3:0], m[0], m[3] ? SUM_MAX : '0, m[2] ? '0 : 10'd1023,
                       m[1] ? '0 : 11'd2047);
            send_bin(pick_mag(STYLE_LOUD), 1'b0);
            send_bin((m % 3 == 0) ? 14'd0 : 14'h3FFF, 1'b1);
            wait_idle();
        end
        directed_bins = bins_sent;

        phase = 0;
        while (bins_sent - directed_bins < RANDOM_BINS) begin
            case (phase)
                0: set_config(4'd15, 1'b1, SUM_MAX, 10'd1023, 11'd2047);
                1: set_config(4'd0, 1'b0, '0, '0, '0);
                default: begin
                    r = $urandom_range(99);
                    if (r < 60)      thr = SUM_W'($urandom_range(300));
                    else if (r < 80) thr = SUM_W'($urandom_range(16383));
                    else if (r < 90) thr = '0;
                    else             thr = SUM_MAX;
                    blank  = ($urandom_range(9) < 7) ? BLANK_W'($urandom_range(6))
                                                     : BLANK_W'($urandom_range(1023));
                    ex_dly = ($urandom_range(9) < 7) ? SIL_W'($urandom_range(12))
                                                     : SIL_W'($urandom_range(2047));
                    set_config(4'($urandom_range(15)), 1'($urandom_range(1)), thr, blank,
                               ex_dly);
                end
            endcase
            // One phase runs with neither side idling.
            calm = (phase == 2);
            repeat ($urandom_range(3, 7)) begin
                r = $urandom_range(99);
                if (r < 65)      len = $urandom_range(1, 10);
                else if (r < 88) len = $urandom_range(11, 40);
                else             len = NUM_BINS;
                send_frame(len, mag_style_e'($urandom_range(3)),
                           (len < NUM_BINS) || ($urandom_range(1) == 1));
            end
            wait_idle();
            phase++;
        end
        calm = 1'b0;

        i_in_valid <= 1'b0;
        while (pred.due_columns.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("summary: %0d bins in %0d frames over %0d random phases, %0d columns checked",
                 bins_sent, pred.frames, phase, pred.checked);
        $display("summary: %0d frames with sound, %0d blanked, %0d with exit request, %0d errors",
                 pred.loud_frames, pred.dark_frames, pred.exit_frames, pred.errors);
        if (pred.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/sbph_pkg.sv
rtl/sbph_ram.sv
rtl/sbph_ctrl.sv
rtl/sbph_datapath.sv
rtl/spectrum_bar_peak_hold.sv
sim/spectrum_bar_peak_hold_tb.sv
